### rtl/core/smbc_pkg.sv
// ----------------------------------------------------------------------------
// smbc_pkg
// shared types and constants of the bank conflict counter
// ----------------------------------------------------------------------------
package smbc_pkg;

    // default sizes
    localparam int DEF_LANES     = 8;
    localparam int DEF_MAX_BANKS = 32;
    localparam int DEF_ADDR_BITS = 32;

    // field widths
    localparam int LCNT_W = 4;
    localparam int REQ_W  = 16;
    localparam int TOT_W  = 32;
    localparam int BC_W   = 6;
    localparam int BW_W   = 9;

    localparam int OUT_TDATA_W = REQ_W + TOT_W;

    localparam logic [REQ_W-1:0] REQ_MAX = '1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_WIDTH = 1'd1;

    localparam logic [BC_W-1:0] BANK_COUNT_RST = 6'd32;
    localparam logic [BW_W-1:0] BANK_WIDTH_RST = 9'd4;

    // address bits retired per cycle in each lane remainder unit
    localparam int DIV_STEP = 4;

    typedef struct packed {
        logic load;
        logic shift;
        logic fin;
    } t_lane_ctl;

    typedef struct packed {
        logic hit;
        logic count;
        logic last;
        logic en;
    } t_mrg_ctl;

endpackage

### rtl/core/smbc_lane.sv
// ----------------------------------------------------------------------------
// smbc_lane
// per-lane bank index unit: (addr mod (width*banks)) / width
// ----------------------------------------------------------------------------
module smbc_lane import smbc_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int M_W       = 15,
    parameter int BANK_W    = 5
) (
    input  logic                 i_clk,
    input  t_lane_ctl            i_ctl,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [M_W-1:0]       i_mod,
    input  logic [BW_W-1:0]      i_width,
    output logic [BANK_W-1:0]    o_bank
);

    localparam int DIV_CYC = (ADDR_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_W   = DIV_CYC * DIV_STEP;

    logic [PAD_W-1:0]  r_addr;
    logic [M_W-1:0]    r_rem;
    logic [M_W-1:0]    n_rem;
    logic [BANK_W-1:0] r_bank;
    logic [BANK_W-1:0] n_bank;

    // restoring remainder, msb first, DIV_STEP address bits a cycle
    always_comb begin
        logic [M_W:0] v;
        v = {1'b0, r_rem};
        for (int k = 0; k < DIV_STEP; k++) begin
            v = {v[M_W-1:0], r_addr[PAD_W-1-k]};
            if (v >= {1'b0, i_mod}) begin
                v = v - {1'b0, i_mod};
            end
        end
        n_rem = v[M_W-1:0];
    end

    // quotient of the remainder by the width is below the bank count
    always_comb begin
        logic [M_W-1:0] r;
        logic [M_W-1:0] d;
        r      = r_rem;
        n_bank = '0;
        for (int k = BANK_W - 1; k >= 0; k--) begin
            d = M_W'(i_width) << k;
            if (r >= d) begin
                r         = r - d;
                n_bank[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_addr <= PAD_W'(i_addr);
            r_rem  <= '0;
        end else if (i_ctl.shift) begin
            r_addr <= r_addr << DIV_STEP;
            r_rem  <= n_rem;
        end
        if (i_ctl.fin) begin
            r_bank <= n_bank;
        end
    end

    assign o_bank = r_bank;

endmodule

### rtl/core/smbc_merge.sv
// ----------------------------------------------------------------------------
// smbc_merge
// combines lane banks: conflict flags, bank-seen map, request and total counts
// ----------------------------------------------------------------------------
module smbc_merge import smbc_pkg::*; #(
    parameter int LANES     = DEF_LANES,
    parameter int MAX_BANKS = DEF_MAX_BANKS,
    parameter int BANK_W    = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_mrg_ctl                     i_ctl,
    input  logic [LANES-1:0][BANK_W-1:0] i_bank,
    input  logic [LANES-1:0]             i_vld,
    output logic [REQ_W-1:0]             o_req,
    output logic [TOT_W-1:0]             o_tot
);

    localparam int HC_W  = $clog2(LANES + 1);
    localparam int SUM_W = REQ_W + 1;

    logic [MAX_BANKS-1:0] r_seen;
    logic [MAX_BANKS-1:0] n_seen;
    logic [LANES-1:0]     r_hit;
    logic [LANES-1:0]     n_hit;
    logic [REQ_W-1:0]     r_pend;
    logic [REQ_W-1:0]     n_pend;
    logic [TOT_W-1:0]     r_total;
    logic [HC_W-1:0]      hit_cnt;

    // a lane hits if its bank was seen before or a lower valid lane shares it
    always_comb begin
        logic [LANES-1:0] m;
        m = '0;
        for (int i = 0; i < LANES; i++) begin
            for (int j = 0; j < i; j++) begin
                if (i_vld[j] && (i_bank[j] == i_bank[i])) begin
                    m[i] = 1'b1;
                end
            end
            n_hit[i] = i_ctl.en && i_vld[i] && (r_seen[i_bank[i]] || m[i]);
        end
    end

    always_comb begin
        n_seen = r_seen;
        for (int b = 0; b < MAX_BANKS; b++) begin
            for (int i = 0; i < LANES; i++) begin
                if (i_vld[i] && (i_bank[i] == BANK_W'(b))) begin
                    n_seen[b] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        logic [SUM_W-1:0] s;
        hit_cnt = '0;
        for (int i = 0; i < LANES; i++) begin
            hit_cnt = hit_cnt + HC_W'(r_hit[i]);
        end
        s = {1'b0, r_pend} + SUM_W'(hit_cnt);
        if (s > SUM_W'(REQ_MAX)) begin
            n_pend = REQ_MAX;
        end else begin
            n_pend = s[REQ_W-1:0];
        end
    end

    assign o_req = n_pend;
    assign o_tot = r_total + TOT_W'(hit_cnt);

    always_ff @(posedge i_clk) begin
        if (i_ctl.hit) begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_pend  <= '0;
            r_total <= '0;
        end else begin
            if (i_ctl.hit) begin
                if (i_ctl.last) begin
                    r_seen <= '0;
                end else if (i_ctl.en) begin
                    r_seen <= n_seen;
                end
            end
            if (i_ctl.count) begin
                r_total <= o_tot;
                r_pend  <= i_ctl.last ? '0 : n_pend;
            end
        end
    end

endmodule

### rtl/core/shared_memory_bank_conflict_count.sv
// ----------------------------------------------------------------------------
// shared_memory_bank_conflict_count
// counts shared-memory bank conflicts per request and in a running total
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_axis   | in  | tvalid / tready    | tdata: addr0..addr(LANES-1), lane_count
//           |     |                    | tlast: last_of_request
//  m_axis   | out | tvalid / tready    | tdata: request_conflicts, total_conflicts
//  cfg      | in  | write enable only  | idx 0 bank_count, idx 1 bank_width
//
// one word at a time: after an accept a word goes through the divide, finish,
// merge and count states before the next accept; the lane remainder units
// retire four address bits per cycle in the divide state.
// synchronous active-low reset; config is reset to 32 banks of 4 bytes.
// the result sits in an output register; a last word waits in the count
// stage only while a previous result is still not taken.
// ----------------------------------------------------------------------------
module shared_memory_bank_conflict_count import smbc_pkg::*; #(
    parameter  int LANES     = DEF_LANES,
    parameter  int MAX_BANKS = DEF_MAX_BANKS,
    parameter  int ADDR_BITS = DEF_ADDR_BITS,
    localparam int S_TDATA_W = ((LANES * ADDR_BITS + LCNT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // addr0 .. addr(LANES-1), lane_count, zero fill
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // request_conflicts, total_conflicts
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CNT_W   = $clog2(MAX_BANKS + 1);
    localparam int BANK_W  = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int M_W     = BW_W + CNT_W;
    localparam int DIV_CYC = (ADDR_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DC_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_FIN  = 5'b00100,
        S_MRG  = 5'b01000,
        S_CNT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [BC_W-1:0]  r_bank_count;
    logic [BW_W-1:0]  r_bank_width;
    logic [BW_W-1:0]  r_wid;
    logic [M_W-1:0]   r_mod;
    logic [CNT_W-1:0] eff_banks;
    logic [BW_W-1:0]  eff_width;

    logic [DC_W-1:0]  r_cnt;
    logic [LANES-1:0] r_vld;
    logic [LANES-1:0] n_vld;
    logic             r_last;

    logic             r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                         s_acc;
    logic                         cnt_go;
    t_lane_ctl                    lane_ctl;
    t_mrg_ctl                     mrg_ctl;
    logic [LANES-1:0][BANK_W-1:0] lane_bank;
    logic [LCNT_W-1:0]            in_lcnt;
    logic [REQ_W-1:0]             mrg_req;
    logic [TOT_W-1:0]             mrg_tot;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_count <= BANK_COUNT_RST;
            r_bank_width <= BANK_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BANK_COUNT: r_bank_count <= i_cfg_data[BC_W-1:0];
                CFG_BANK_WIDTH: r_bank_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if ({1'b0, r_bank_count} > 7'(MAX_BANKS)) begin
            eff_banks = CNT_W'(MAX_BANKS);
        end else begin
            eff_banks = CNT_W'(r_bank_count);
        end
        eff_width = (r_bank_width == '0) ? BW_W'(1) : r_bank_width;
    end

    // modulus of the whole address: width * banks
    always_ff @(posedge i_clk) begin
        r_wid <= eff_width;
        r_mod <= M_W'(eff_width) * M_W'(eff_banks);
    end

    // sequencer
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign cnt_go     = (r_state == S_CNT) && (!r_last || !r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_acc) n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_FIN;
            S_FIN:  n_state = S_MRG;
            S_MRG:  n_state = S_CNT;
            S_CNT:  if (cnt_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign in_lcnt = i_s_tdata[LANES*ADDR_BITS +: LCNT_W];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_vld[i] = (7'(i) < 7'(in_lcnt));
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cnt  <= DC_W'(DIV_CYC - 1);
            r_vld  <= n_vld;
            r_last <= i_s_tlast;
        end else if (r_state == S_DIV) begin
            r_cnt <= r_cnt - DC_W'(1);
        end
    end

    // lanes
    assign lane_ctl.load  = s_acc;
    assign lane_ctl.shift = (r_state == S_DIV);
    assign lane_ctl.fin   = (r_state == S_FIN);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        smbc_lane #(
            .ADDR_BITS (ADDR_BITS),
            .M_W       (M_W),
            .BANK_W    (BANK_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_addr  (i_s_tdata[g*ADDR_BITS +: ADDR_BITS]),
            .i_mod   (r_mod),
            .i_width (r_wid),
            .o_bank  (lane_bank[g])
        );
    end

    // merge
    assign mrg_ctl.hit   = (r_state == S_MRG);
    assign mrg_ctl.count = cnt_go;
    assign mrg_ctl.last  = r_last;
    assign mrg_ctl.en    = (r_bank_count != '0);

    smbc_merge #(
        .LANES     (LANES),
        .MAX_BANKS (MAX_BANKS),
        .BANK_W    (BANK_W)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mrg_ctl),
        .i_bank  (lane_bank),
        .i_vld   (r_vld),
        .o_req   (mrg_req),
        .o_tot   (mrg_tot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cnt_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_go && r_last) begin
            r_out_data <= {mrg_tot, mrg_req};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### rtl/core/smbc_check.sv
// ----------------------------------------------------------------------------
// smbc_check
// port-level checks of the bank conflict counter, bound to the top level
// ----------------------------------------------------------------------------
module smbc_check import smbc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // reset leaves no result and an open input
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("bad state after reset");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("word taken while busy");

    // the input stays busy while the remainder units work
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |-> ##2 !o_s_tready)
        else $error("word taken before lanes finished");

endmodule

bind shared_memory_bank_conflict_count smbc_check u_smbc_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### dv/shared_memory_bank_conflict_count_tb.sv
// ----------------------------------------------------------------------------
// shared_memory_bank_conflict_count_tb
// drives address words into the bank conflict counter and checks every
// per-request count and running total against a cycle-free predictor,
// over reset defaults, corner configurations, one long request and
// random requests, with random gaps and stalls on both streams
// ----------------------------------------------------------------------------
module shared_memory_bank_conflict_count_tb;
    import smbc_pkg::*;

    localparam int NLANES       = DEF_LANES;
    localparam int ABITS        = DEF_ADDR_BITS;
    localparam int NBANKS       = DEF_MAX_BANKS;
    localparam int S_W          = ((NLANES * ABITS + LCNT_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 1_500_000;

    typedef logic [NLANES-1:0][ABITS-1:0] t_lane_addr;

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [TOT_W-1:0] tot;
    } t_conflict_result;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    // addr0 .. addr7, lane_count, zero fill
    logic [S_W-1:0]         i_s_tdata  = '0;
    logic                   i_s_tlast  = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // request_conflicts, total_conflicts
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = CFG_BANK_COUNT;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    shared_memory_bank_conflict_count dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [BC_W-1:0]    cfg_banks_q = BANK_COUNT_RST;
    logic [BW_W-1:0]    cfg_width_q = BANK_WIDTH_RST;
    logic [NBANKS-1:0]  bank_seen_mask = '0;
    int unsigned        req_conflicts_acc = 0;
    logic [TOT_W-1:0]   total_conflicts_acc = '0;
    t_conflict_result   expected_results[$];

    int unsigned errors = 0;
    int unsigned words_sent = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned cycles = 0;
    bit          no_idle = 1'b0;

    function automatic void predict_word(input t_lane_addr addr, input logic [3:0] lanes,
                                         input logic last);
        int unsigned      nb;
        int unsigned      wd;
        int unsigned      nl;
        int unsigned      bank;
        int unsigned      hits;
        t_conflict_result r;
        nb = (cfg_banks_q > NBANKS) ? NBANKS : cfg_banks_q;
        wd = (cfg_width_q == 0) ? 1 : cfg_width_q;
        nl = (lanes > NLANES) ? NLANES : lanes;
        hits = 0;
        if (nb != 0) begin
            for (int i = 0; i < nl; i++) begin
                bank = (addr[i] / wd) % nb;
                if (bank_seen_mask[bank]) hits++;
                else bank_seen_mask[bank] = 1'b1;
            end
        end
        req_conflicts_acc += hits;
        if (req_conflicts_acc > REQ_MAX) req_conflicts_acc = 32'(REQ_MAX);
        total_conflicts_acc += hits;
        if (last) begin
            r.req = req_conflicts_acc[REQ_W-1:0];
            r.tot = total_conflicts_acc;
            expected_results.push_back(r);
            bank_seen_mask = '0;
            req_conflicts_acc = 0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_lane_addr stride_addr(input logic [31:0] base, input logic [31:0] step);
        t_lane_addr a;
        for (int i = 0; i < NLANES; i++) a[i] = base + step * i;
        return a;
    endfunction

    task automatic send_word(input t_lane_addr addr, input logic [3:0] lanes, input logic last);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_W - NLANES * ABITS - LCNT_W){1'b0}}, lanes, addr};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_word(addr, lanes, last);
        words_sent++;
        if (last) requests_sent++;
    endtask

    // lets the last result out and the count stage settle before a register write
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] banks, input logic [CFG_DATA_W-1:0] width);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BANK_COUNT;
        i_cfg_data <= banks;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BANK_WIDTH;
        i_cfg_data <= width;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_banks_q = banks[BC_W-1:0];
        cfg_width_q = width;
    endtask

    // receiver: ready held for random stretches, mostly short stalls, a few long
    int unsigned ready_hold = 0;
    always @(posedge i_clk) begin
        int r;
        if (no_idle) begin
            i_m_tready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold != 0) begin
            ready_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_m_tready <= 1'b1;
                ready_hold = $urandom_range(0, 8);
            end else if (r < 92) begin
                i_m_tready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else begin
                i_m_tready <= 1'b0;
                ready_hold = $urandom_range(10, 50);
            end
        end
    end

    always @(posedge i_clk) begin
        t_conflict_result e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word: request_conflicts %0d total_conflicts %0d",
                       o_m_tdata[REQ_W-1:0], o_m_tdata[REQ_W +: TOT_W]);
                errors++;
            end else begin
                e = expected_results.pop_front();
                results_checked++;
                if (o_m_tdata[REQ_W-1:0] !== e.req) begin
                    $error("request_conflicts: expected %0d, got %0d", e.req,
                           o_m_tdata[REQ_W-1:0]);
                    errors++;
                end
                if (o_m_tdata[REQ_W +: TOT_W] !== e.tot) begin
                    $error("total_conflicts: expected %0d, got %0d", e.tot,
                           o_m_tdata[REQ_W +: TOT_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_results.size());
            $display("shared_memory_bank_conflict_count_tb NOT OK");
            $finish;
        end
    end

    // reset values of both registers, lane count corners, cross-word conflicts
    task automatic test_reset_defaults();
        send_word(stride_addr(32'h0, 32'h0), 4'd8, 1'b1);
        send_word(stride_addr(32'h0, 32'd4), 4'd8, 1'b1);
        send_word(stride_addr(32'hFFFF_FFFF, 32'h0), 4'd15, 1'b1);
        send_word(stride_addr(32'h0, 32'h0), 4'd0, 1'b1);
        send_word(stride_addr(32'h0, 32'd4), 4'd4, 1'b0);
        send_word(stride_addr(32'd128, 32'd36), 4'd4, 1'b0);
        send_word(stride_addr(32'd12, 32'h0), 4'd1, 1'b1);
        send_word(stride_addr(32'hAAAA_AAAA, 32'h5555_5555), 4'd9, 1'b0);
        send_word(stride_addr(32'h5555_5555, 32'hAAAA_AAAB), 4'd1, 1'b1);
        wait_drained();
    endtask

    // zero banks, more than the maximum banks, zero and widest bank width
    task automatic test_config_corners();
        set_config(9'd0, 9'd4);
        send_word(stride_addr(32'h0, 32'h0), 4'd8, 1'b0);
        send_word(stride_addr(32'h40, 32'h0), 4'd8, 1'b1);
        wait_drained();
        set_config(9'd63, 9'd1);
        send_word(stride_addr(32'h0, 32'd5), 4'd8, 1'b1);
        wait_drained();
        set_config(9'd40, 9'd0);
        send_word(stride_addr(32'h0, 32'd16), 4'd8, 1'b1);
        wait_drained();
        set_config(9'd32, 9'd511);
        send_word(stride_addr(32'hFFFF_FE00, 32'd511), 4'd8, 1'b1);
        wait_drained();
        set_config(9'd1, 9'd256);
        send_word(stride_addr(32'h1234_5678, 32'h0101_0101), 4'd8, 1'b1);
        wait_drained();
    endtask

    // a single bank and one long request keep the request count climbing over many words
    task automatic test_long_request();
        no_idle = 1'b1;
        set_config(9'd1, 9'd1);
        for (int i = 0; i < 200; i++) begin
            send_word(stride_addr($urandom(), $urandom()), 4'd8, 1'b0);
        end
        send_word(stride_addr($urandom(), $urandom()), 4'd8, 1'b1);
        // next request starts again from zero
        send_word(stride_addr($urandom(), 32'h0), 4'd3, 1'b1);
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic random_request();
        int          n_items;
        int          r;
        int unsigned wd;
        int unsigned nb;
        logic [3:0]  lanes;
        t_lane_addr  a;
        r = $urandom_range(0, 99);
        n_items = (r < 85) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        wd = (cfg_width_q == 0) ? 1 : cfg_width_q;
        nb = (cfg_banks_q == 0) ? 1 : cfg_banks_q;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5) lanes = 4'd0;
            else if (r < 12) lanes = 4'($urandom_range(9, 15));
            else lanes = 4'($urandom_range(1, 8));
            case ($urandom_range(0, 4))
                0: a = stride_addr($urandom(), $urandom());
                1: a = stride_addr($urandom(), 32'h0);
                // consecutive bank words, conflict free within a word when there are at least as many banks as lanes
                2: a = stride_addr($urandom(), wd);
                // same bank, different rows, while the bank count does not exceed NBANKS
                3: a = stride_addr($urandom(), wd * nb * $urandom_range(1, 4));
                default: begin
                    for (int i = 0; i < NLANES; i++) a[i] = $urandom_range(0, 1023);
                end
            endcase
            send_word(a, lanes, k == n_items - 1);
        end
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] banks;
        logic [CFG_DATA_W-1:0] width;
        int                    start;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin banks = 9'd32; width = 9'd4;   end
                1: begin banks = 9'd1;  width = 9'd1;   end
                2: begin banks = 9'd0;  width = 9'd256; end
                3: begin banks = 9'd16; width = 9'd8;   end
                4: begin banks = 9'd63; width = 9'd0;   end
                5: begin banks = 9'd7;  width = 9'd3;   end
                6: begin banks = 9'd32; width = 9'd511; end
                default: begin
                    // bank count upper bits of the data word are don't-care
                    banks = {3'($urandom), 6'($urandom_range(0, 63))};
                    width = 9'($urandom_range(0, 511));
                end
            endcase
            set_config(banks, width);
            no_idle = (p == 3);
            start = words_sent;
            while (words_sent - start < 128) random_request();
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_config_corners();
        test_long_request();
        test_random_phases();
        wait_drained();
        $display("ran %0d words in %0d requests, %0d results checked in %0d cycles",
                 words_sent, requests_sent, results_checked, cycles);
        $display("bank counts 0..63, widths 0..511, lane counts 0..15, one long request");
        if (errors == 0) begin
            $display("shared_memory_bank_conflict_count_tb OK");
        end else begin
            $display("shared_memory_bank_conflict_count_tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/smbc_pkg.sv
rtl/core/smbc_lane.sv
rtl/core/smbc_merge.sv
rtl/core/shared_memory_bank_conflict_count.sv
rtl/core/smbc_check.sv
dv/shared_memory_bank_conflict_count_tb.sv
